[src/cyrillic_vfd_line_transcoder_defines.svh]
// assertion macros for the display line transcoder
`ifndef CYRILLIC_VFD_LINE_TRANSCODER_DEFINES_SVH
`define CYRILLIC_VFD_LINE_TRANSCODER_DEFINES_SVH
`ifndef SYNTH
`define CVLT_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("cvlt assertion failed");
`define CVLT_NEVER(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error("cvlt forbidden condition");
`else
`define CVLT_ASSERT(lbl, prop)
`define CVLT_NEVER(lbl, expr)
`endif
`endif

[src/cvlt_pkg.sv]
package cvlt_pkg;

	localparam int unsigned BYTE_W         = 8;
	localparam int unsigned POS_W          = 6;
	localparam int unsigned LAST_INDEX_DEF = 41;

	localparam logic [BYTE_W-1:0] CODE_END   = 8'h00;
	localparam logic [BYTE_W-1:0] CODE_TAB_A = 8'hAC;
	localparam logic [BYTE_W-1:0] CODE_PAGE0 = 8'hD0;
	localparam logic [BYTE_W-1:0] CODE_PAGE1 = 8'hD1;
	localparam logic [BYTE_W-1:0] CODE_FILL  = 8'hFF;

	typedef struct packed {
		logic take;
		logic fill_step;
	} cvlt_cmd_t;

	typedef struct packed {
		logic term_in;
		logic pos_at_last;
		logic slot_free;
	} cvlt_stat_t;

	function automatic logic [BYTE_W-1:0] lookup_a(input logic [BYTE_W-1:0] c);
		logic [BYTE_W-1:0] r;
		unique case (c)
			8'hA1, 8'hD1: r = 8'h41;
			8'hA2, 8'hD2: r = 8'h80;
			8'hA3, 8'hD3: r = 8'h42;
			8'hA4, 8'hD4: r = 8'h92;
			8'hA5, 8'hD5: r = 8'h81;
			8'hA6, 8'hD6: r = 8'h45;
			8'hA7, 8'hD7: r = 8'hCB;
			8'hA8, 8'hD8: r = 8'h82;
			8'hA9, 8'hD9: r = 8'h83;
			8'hAA, 8'hDA: r = 8'h84;
			8'hAB, 8'hDB: r = 8'h85;
			8'hAC, 8'hDC: r = 8'h4B;
			8'hAD, 8'hDD: r = 8'h86;
			8'hAE, 8'hDE: r = 8'h4D;
			8'hAF, 8'hDF: r = 8'h48;
			8'hB0, 8'hE0: r = 8'h4F;
			8'hB1, 8'hE1: r = 8'h87;
			8'hB2, 8'hE2: r = 8'h50;
			8'hB3, 8'hE3: r = 8'h43;
			8'hB4, 8'hE4: r = 8'h54;
			8'hB5, 8'hE5: r = 8'h88;
			8'hB6, 8'hE6: r = 8'hD8;
			8'hB7, 8'hE7: r = 8'h58;
			8'hB8, 8'hE8: r = 8'h89;
			8'hB9, 8'hE9: r = 8'h8A;
			8'hBA, 8'hEA: r = 8'h8B;
			8'hBB, 8'hEB: r = 8'h8C;
			8'hBC, 8'hEC: r = 8'h8D;
			8'hBD, 8'hED: r = 8'h8E;
			8'hBE, 8'hEE: r = 8'h62;
			8'hBF, 8'hEF: r = 8'h8F;
			8'hC0, 8'hF0: r = 8'hAC;
			8'hC1, 8'hF1: r = 8'hAD;
			default:      r = c;
		endcase
		return r;
	endfunction

	function automatic logic [BYTE_W-1:0] lookup_b0(input logic [BYTE_W-1:0] c);
		logic [BYTE_W-1:0] r;
		unique case (c)
			8'h90, 8'hB0: r = 8'h41;
			8'h91, 8'hB1: r = 8'h80;
			8'h92, 8'hB2: r = 8'h42;
			8'h93, 8'hB3: r = 8'h92;
			8'h94, 8'hB4: r = 8'h81;
			8'h95, 8'hB5: r = 8'h45;
			8'h96, 8'hB6: r = 8'h82;
			8'h97, 8'hB7: r = 8'h83;
			8'h98, 8'hB8: r = 8'h84;
			8'h99, 8'hB9: r = 8'h85;
			8'h9A, 8'hBA: r = 8'h4B;
			8'h9B, 8'hBB: r = 8'h86;
			8'h9C, 8'hBC: r = 8'h4D;
			8'h9D, 8'hBD: r = 8'h48;
			8'h9E, 8'hBE: r = 8'h4F;
			8'h9F, 8'hBF: r = 8'h87;
			8'h81:        r = 8'hCB;
			8'hA0:        r = 8'h50;
			8'hA1:        r = 8'h43;
			8'hA2:        r = 8'h54;
			8'hA3:        r = 8'h88;
			8'hA4:        r = 8'hD8;
			8'hA5:        r = 8'h58;
			8'hA6:        r = 8'h89;
			8'hA7:        r = 8'h8A;
			8'hA8:        r = 8'h8B;
			8'hA9:        r = 8'h8C;
			8'hAA:        r = 8'h8D;
			8'hAB:        r = 8'h8E;
			8'hAC:        r = 8'h62;
			8'hAD:        r = 8'h8F;
			8'hAE:        r = 8'hAC;
			8'hAF:        r = 8'hAD;
			default:      r = c;
		endcase
		return r;
	endfunction

	function automatic logic [BYTE_W-1:0] lookup_b1(input logic [BYTE_W-1:0] c);
		logic [BYTE_W-1:0] r;
		unique case (c)
			8'h84:   r = 8'hD8;
			8'h91:   r = 8'hCB;
			8'hB7:   r = 8'h83;
			8'hB8:   r = 8'h84;
			8'hB9:   r = 8'h85;
			8'hBA:   r = 8'h4B;
			8'hBB:   r = 8'h86;
			8'hBC:   r = 8'h4D;
			8'hBD:   r = 8'h48;
			8'hBE:   r = 8'h4F;
			8'hBF:   r = 8'h87;
			8'h80:   r = 8'h50;
			8'h81:   r = 8'h43;
			8'h82:   r = 8'h54;
			8'h83:   r = 8'h88;
			8'h85:   r = 8'h58;
			8'h86:   r = 8'h89;
			8'h87:   r = 8'h8A;
			8'h88:   r = 8'h8B;
			8'h89:   r = 8'h8C;
			8'h8A:   r = 8'h8D;
			8'h8B:   r = 8'h8E;
			8'h8C:   r = 8'h62;
			8'h8D:   r = 8'h8F;
			8'h8E:   r = 8'hAC;
			8'h8F:   r = 8'hAD;
			default: r = c;
		endcase
		return r;
	endfunction

endpackage

[src/cvlt_code_if.sv]
interface cvlt_code_if import cvlt_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] code_byte;

	modport source (output valid, output code_byte, input ready);
	modport sink   (input valid, input code_byte, output ready);
endinterface

[src/cvlt_disp_if.sv]
interface cvlt_disp_if import cvlt_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] display_byte;
	logic [POS_W-1:0]  position;
	logic              last_of_line;
	logic              overflowed;

	modport source (output valid, output display_byte, output position,
		output last_of_line, output overflowed, input ready);
	modport sink   (input valid, input display_byte, input position,
		input last_of_line, input overflowed, output ready);
endinterface

[src/cvlt_ctrl.sv]
module cvlt_ctrl import cvlt_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  cvlt_stat_t stat,
	output logic       in_ready,
	output cvlt_cmd_t  cmd
);

	typedef enum logic {ST_TEXT, ST_FILL} state_t;

	state_t state_q;

	assign in_ready      = (state_q == ST_TEXT) && stat.slot_free;
	assign cmd.take      = in_valid && in_ready;
	assign cmd.fill_step = (state_q == ST_FILL) && stat.slot_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_TEXT;
		end else begin
			unique case (state_q)
				ST_TEXT: begin
					if (cmd.take && stat.term_in && !stat.pos_at_last) begin
						state_q <= ST_FILL;
					end
				end
				ST_FILL: begin
					if (cmd.fill_step && stat.pos_at_last) begin
						state_q <= ST_TEXT;
					end
				end
				default: state_q <= ST_TEXT;
			endcase
		end
	end

endmodule

[src/cvlt_datapath.sv]
module cvlt_datapath import cvlt_pkg::*; #(
	parameter int unsigned LAST_INDEX = LAST_INDEX_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [BYTE_W-1:0] code_byte,
	input  cvlt_cmd_t         cmd,
	output cvlt_stat_t        stat,
	input  logic              out_ready,
	output logic              out_valid,
	output logic [BYTE_W-1:0] display_byte,
	output logic [POS_W-1:0]  position,
	output logic              last_of_line,
	output logic              overflowed
);

	localparam logic [POS_W-1:0] LastPos = POS_W'(LAST_INDEX);

	typedef enum logic [1:0] {PFX_NONE, PFX_TAB_A, PFX_PAGE} pfx_t;

	pfx_t              prefix_q;
	logic              page_q;
	logic [POS_W-1:0]  pos_q;
	logic              ovf_q;
	logic              valid_q;
	logic [BYTE_W-1:0] byte_q;
	logic [POS_W-1:0]  opos_q;
	logic              last_q;
	logic              oovf_q;

	logic              is_prefix_a;
	logic              is_prefix_p;
	logic              is_term;
	logic              pos_full;
	logic [BYTE_W-1:0] glyph;
	logic              emit;
	logic [BYTE_W-1:0] emit_byte;

	assign is_prefix_a = (prefix_q == PFX_NONE) && (code_byte == CODE_TAB_A);
	assign is_prefix_p = (prefix_q == PFX_NONE) &&
		((code_byte == CODE_PAGE0) || (code_byte == CODE_PAGE1));
	assign is_term     = (code_byte == CODE_END);
	assign pos_full    = (pos_q == LastPos);

	always_comb begin
		if (prefix_q == PFX_TAB_A) begin
			glyph = lookup_a(code_byte);
		end else if (page_q) begin
			glyph = lookup_b1(code_byte);
		end else begin
			glyph = lookup_b0(code_byte);
		end
	end

	always_comb begin
		emit      = 1'b0;
		emit_byte = glyph;
		if (cmd.take) begin
			priority if (is_prefix_a || is_prefix_p) begin
				emit = 1'b0;
			end else if (is_term) begin
				emit      = 1'b1;
				emit_byte = CODE_END;
			end else begin
				emit = !pos_full;
			end
		end else if (cmd.fill_step) begin
			emit      = 1'b1;
			emit_byte = pos_full ? CODE_END : CODE_FILL;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prefix_q <= PFX_NONE;
			page_q   <= 1'b0;
			pos_q    <= '0;
			ovf_q    <= 1'b0;
			valid_q  <= 1'b0;
		end else begin
			if (cmd.take) begin
				priority if (is_prefix_a) begin
					prefix_q <= PFX_TAB_A;
				end else if (is_prefix_p) begin
					prefix_q <= PFX_PAGE;
					page_q   <= code_byte[0];
				end else if (is_term) begin
					prefix_q <= PFX_NONE;
					page_q   <= 1'b0;
					if (pos_full) begin
						pos_q <= '0;
						ovf_q <= 1'b0;
					end else begin
						pos_q <= pos_q + 1'b1;
					end
				end else begin
					prefix_q <= PFX_NONE;
					if (pos_full) begin
						ovf_q <= 1'b1;
					end else begin
						pos_q <= pos_q + 1'b1;
					end
				end
			end else if (cmd.fill_step) begin
				if (pos_full) begin
					pos_q <= '0;
					ovf_q <= 1'b0;
				end else begin
					pos_q <= pos_q + 1'b1;
				end
			end
			if (emit) begin
				valid_q <= 1'b1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			byte_q <= emit_byte;
			opos_q <= pos_q;
			last_q <= pos_full;
			oovf_q <= ovf_q;
		end
	end

	assign stat.term_in     = is_term;
	assign stat.pos_at_last = pos_full;
	assign stat.slot_free   = !valid_q || out_ready;

	assign out_valid    = valid_q;
	assign display_byte = byte_q;
	assign position     = opos_q;
	assign last_of_line = last_q;
	assign overflowed   = oovf_q;

endmodule

[src/cyrillic_vfd_line_transcoder.sv]
// a result is registered and becomes valid in the cycle after the request that causes it
// throughput: one text byte per cycle while the output is taken
// terminator at position p: LAST_INDEX - p + 1 output bytes, input held off while the line is filled up to LAST_INDEX
// line position counter and the output register set the pace, one byte per cycle while the output is taken
// reset: asynchronous, clears prefix, page, position, overflow and output valid
`include "cyrillic_vfd_line_transcoder_defines.svh"
module cyrillic_vfd_line_transcoder import cvlt_pkg::*; #(
	parameter int unsigned LAST_INDEX = LAST_INDEX_DEF
) (
	input logic         clk,
	input logic         arst_n,
	cvlt_code_if.sink   code,
	cvlt_disp_if.source disp
);

	localparam logic [POS_W-1:0] LastPos = POS_W'(LAST_INDEX);

	cvlt_cmd_t  cmd;
	cvlt_stat_t stat;
	logic       in_ready;

	cvlt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (code.valid),
		.stat     (stat),
		.in_ready (in_ready),
		.cmd      (cmd)
	);

	cvlt_datapath #(
		.LAST_INDEX (LAST_INDEX)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.code_byte    (code.code_byte),
		.cmd          (cmd),
		.stat         (stat),
		.out_ready    (disp.ready),
		.out_valid    (disp.valid),
		.display_byte (disp.display_byte),
		.position     (disp.position),
		.last_of_line (disp.last_of_line),
		.overflowed   (disp.overflowed)
	);

	assign code.ready = in_ready;

	`CVLT_ASSERT(a_last_at_end, disp.valid |-> (disp.last_of_line == (disp.position == LastPos)))
	`CVLT_NEVER(a_take_in_fill, cmd.take && cmd.fill_step)
	`CVLT_ASSERT(a_line_restart, cmd.fill_step && stat.pos_at_last |=> !stat.pos_at_last)
	`CVLT_NEVER(a_pos_range, disp.valid && (disp.position > LastPos))

endmodule

[tb/testbench.sv]
module testbench;
	import cvlt_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned LINE_LAST  = LAST_INDEX_DEF;
	localparam int unsigned IDLE_LIMIT = 2000;
	localparam int unsigned ITEM_COUNT = 410;
	localparam int unsigned DRAIN_WAIT = LINE_LAST + 10;

	// font tables, first entry in the top byte
	localparam logic [33*8-1:0] FONT_A = {
		8'h41, 8'h80, 8'h42, 8'h92, 8'h81, 8'h45, 8'hCB, 8'h82, 8'h83, 8'h84, 8'h85,
		8'h4B, 8'h86, 8'h4D, 8'h48, 8'h4F, 8'h87, 8'h50, 8'h43, 8'h54, 8'h88, 8'hD8,
		8'h58, 8'h89, 8'h8A, 8'h8B, 8'h8C, 8'h8D, 8'h8E, 8'h62, 8'h8F, 8'hAC, 8'hAD
	};
	localparam logic [16*8-1:0] CYR_UPPER = {
		8'h41, 8'h80, 8'h42, 8'h92, 8'h81, 8'h45, 8'h82, 8'h83,
		8'h84, 8'h85, 8'h4B, 8'h86, 8'h4D, 8'h48, 8'h4F, 8'h87
	};
	localparam logic [16*8-1:0] CYR_LOWER = {
		8'h50, 8'h43, 8'h54, 8'h88, 8'hD8, 8'h58, 8'h89, 8'h8A,
		8'h8B, 8'h8C, 8'h8D, 8'h8E, 8'h62, 8'h8F, 8'hAC, 8'hAD
	};
	localparam logic [BYTE_W-1:0] CODE_SOFT = 8'hCB;

	typedef enum logic [1:0] {
		PFX_NONE   = 2'd0,
		PFX_FONT_A = 2'd1,
		PFX_PAGE   = 2'd2
	} prefix_t;

	typedef struct packed {
		logic [BYTE_W-1:0] display_byte;
		logic [POS_W-1:0]  position;
		logic              last_of_line;
		logic              overflowed;
	} disp_item_t;

	function automatic logic [BYTE_W-1:0] pick(input logic [33*8-1:0] tbl, input int n,
		input int idx);
		return tbl[(n-1-idx)*8 +: 8];
	endfunction

	function automatic logic [BYTE_W-1:0] font_code(input prefix_t mode, input logic page,
		input logic [BYTE_W-1:0] c);
		logic [BYTE_W-1:0] r;
		r = c;
		if (mode == PFX_FONT_A) begin
			if (c >= 8'hA1 && c <= 8'hC1)
				r = pick(FONT_A, 33, int'(c - 8'hA1));
			else if (c >= 8'hD1 && c <= 8'hF1)
				r = pick(FONT_A, 33, int'(c - 8'hD1));
		end else if (!page) begin
			if (c >= 8'h90 && c <= 8'h9F)
				r = pick((33*8)'(CYR_UPPER), 16, int'(c - 8'h90));
			else if (c >= 8'hB0 && c <= 8'hBF)
				r = pick((33*8)'(CYR_UPPER), 16, int'(c - 8'hB0));
			else if (c >= 8'hA0 && c <= 8'hAF)
				r = pick((33*8)'(CYR_LOWER), 16, int'(c - 8'hA0));
			else if (c == 8'h81)
				r = CODE_SOFT;
		end else begin
			if (c >= 8'h80 && c <= 8'h8F)
				r = pick((33*8)'(CYR_LOWER), 16, int'(c - 8'h80));
			else if (c >= 8'hB7 && c <= 8'hBF)
				r = pick((33*8)'(CYR_UPPER), 16, int'(c - 8'hB0));
			else if (c == 8'h91)
				r = CODE_SOFT;
		end
		return r;
	endfunction

	class line_scoreboard;
		disp_item_t        line_q[$];
		prefix_t           mode;
		logic              page;
		logic [POS_W-1:0]  next_pos;
		logic              dropped;
		int unsigned       errors;

		function new();
			clear_line();
			errors = 0;
		endfunction

		function void clear_line();
			mode     = PFX_NONE;
			page     = 1'b0;
			next_pos = '0;
			dropped  = 1'b0;
		endfunction

		function void add_byte(input logic [BYTE_W-1:0] b, input int unsigned p);
			disp_item_t it;
			it.display_byte = b;
			it.position     = p[POS_W-1:0];
			it.last_of_line = (p == LINE_LAST);
			it.overflowed   = dropped;
			line_q.push_back(it);
		endfunction

		function void note_request(input logic [BYTE_W-1:0] c);
			logic [BYTE_W-1:0] code;
			if (mode == PFX_NONE && c == CODE_TAB_A) begin
				mode = PFX_FONT_A;
				return;
			end
			if (mode == PFX_NONE && (c == CODE_PAGE0 || c == CODE_PAGE1)) begin
				page = c[0];
				mode = PFX_PAGE;
				return;
			end
			if (c == CODE_END) begin
				if (next_pos < LINE_LAST) begin
					add_byte(CODE_END, 32'(next_pos));
					for (int unsigned p = 32'(next_pos) + 1; p < LINE_LAST; p++)
						add_byte(CODE_FILL, p);
				end
				add_byte(CODE_END, LINE_LAST);
				clear_line();
				return;
			end
			code = font_code(mode, page, c);
			mode = PFX_NONE;
			if (next_pos < LINE_LAST) begin
				add_byte(code, 32'(next_pos));
				next_pos = next_pos + 1'b1;
			end else begin
				dropped = 1'b1;
			end
		endfunction

		function void check_result(input disp_item_t got);
			disp_item_t want;
			if (line_q.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected byte %h pos %0d last %b ovf %b", got.display_byte,
						got.position, got.last_of_line, got.overflowed);
				return;
			end
			want = line_q.pop_front();
			if (got.display_byte !== want.display_byte || got.position !== want.position ||
				got.last_of_line !== want.last_of_line || got.overflowed !== want.overflowed) begin
				errors++;
				if (errors <= 10)
					$display("mismatch exp byte %h pos %0d last %b ovf %b, got byte %h pos %0d last %b ovf %b",
						want.display_byte, want.position, want.last_of_line, want.overflowed,
						got.display_byte, got.position, got.last_of_line, got.overflowed);
			end
		endfunction

		function int unsigned pending();
			return line_q.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	cvlt_code_if code_ch ();
	cvlt_disp_if disp_ch ();

	cyrillic_vfd_line_transcoder #(
		.LAST_INDEX(LINE_LAST)
	) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.code   (code_ch),
		.disp   (disp_ch)
	);

	line_scoreboard sb = new();
	int unsigned    items_sent = 0;
	int unsigned    idle_cycles = 0;
	bit             tx_burst = 1'b0;
	bit             rx_burst = 1'b0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// called at a falling edge, returns at a falling edge with valid still high
	task automatic send_code(input logic [BYTE_W-1:0] b);
		int gap;
		gap = tx_burst ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			code_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		code_ch.valid     = 1'b1;
		code_ch.code_byte = b;
		do @(posedge clk); while (!code_ch.ready);
		sb.note_request(b);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic send_prefix();
		case ($urandom_range(0, 2))
			0:       send_code(CODE_TAB_A);
			1:       send_code(CODE_PAGE0);
			default: send_code(CODE_PAGE1);
		endcase
	endtask

	task automatic send_char();
		int kind;
		int sub;
		kind = $urandom_range(0, 99);
		sub  = $urandom_range(0, 3);
		if (kind < 5) begin
			send_code(BYTE_W'($urandom_range(0, 255)));
		end else if (kind < 55) begin
			send_code(BYTE_W'($urandom_range(1, 255)));
		end else if (kind < 80) begin
			send_code(CODE_TAB_A);
			if (sub == 0)
				send_code(BYTE_W'($urandom_range(8'hA1, 8'hC1)));
			else if (sub == 1)
				send_code(BYTE_W'($urandom_range(8'hD1, 8'hF1)));
			else
				send_code(BYTE_W'($urandom_range(1, 255)));
		end else begin
			send_code($urandom_range(0, 1) ? CODE_PAGE1 : CODE_PAGE0);
			if (sub < 3)
				send_code(BYTE_W'($urandom_range(8'h80, 8'hBF)));
			else
				send_code(BYTE_W'($urandom_range(1, 255)));
		end
	endtask

	task automatic send_line();
		int len;
		case ($urandom_range(0, 9))
			0:       len = 0;
			1:       len = $urandom_range(LINE_LAST - 2, LINE_LAST);
			2:       len = $urandom_range(LINE_LAST + 1, LINE_LAST + 9);
			default: len = $urandom_range(1, 15);
		endcase
		tx_burst = ($urandom_range(0, 3) == 0);
		for (int i = 0; i < len; i++)
			send_char();
		if ($urandom_range(0, 7) == 0)
			send_prefix();
		send_code(CODE_END);
	endtask

	task automatic wait_drained();
		code_ch.valid = 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
	endtask

	initial begin
		logic [BYTE_W-1:0] directed_q[$];
		bit                paused;
		directed_q = '{8'h01, 8'hFF, 8'h7F,
			CODE_TAB_A, 8'hA1, CODE_TAB_A, 8'hF1, CODE_TAB_A, CODE_TAB_A,
			CODE_TAB_A, CODE_PAGE0,
			CODE_PAGE0, 8'h90, CODE_PAGE0, CODE_PAGE1, CODE_PAGE0, 8'h81,
			CODE_PAGE1, 8'h8F, CODE_PAGE1, 8'h91, CODE_PAGE1, CODE_PAGE0,
			CODE_TAB_A, CODE_END,
			CODE_END};
		paused            = 1'b0;
		arst_n            = 1'b0;
		code_ch.valid     = 1'b0;
		code_ch.code_byte = '0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (directed_q[i])
			send_code(directed_q[i]);

		while (items_sent < ITEM_COUNT) begin
			send_line();
			// hold off until the display side has caught up
			if (!paused && items_sent > ITEM_COUNT / 2) begin
				wait_drained();
				paused = 1'b1;
			end
		end

		wait_drained();
		repeat (DRAIN_WAIT) @(posedge clk);
		if (sb.errors == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

	initial begin
		int gap;
		disp_ch.ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if ($urandom_range(0, 29) == 0)
				rx_burst = !rx_burst;
			gap = rx_burst ? 0 : $urandom_range(0, 10);
			if (gap > 0) begin
				disp_ch.ready = 1'b0;
				repeat (gap) @(negedge clk);
			end
			disp_ch.ready = 1'b1;
			do @(posedge clk); while (!disp_ch.valid);
			@(negedge clk);
		end
	end

	always @(posedge clk) begin
		disp_item_t got;
		if (arst_n && disp_ch.valid && disp_ch.ready) begin
			got.display_byte = disp_ch.display_byte;
			got.position     = disp_ch.position;
			got.last_of_line = disp_ch.last_of_line;
			got.overflowed   = disp_ch.overflowed;
			sb.check_result(got);
		end
	end

	// no request and no result for too long
	always @(posedge clk) begin
		if (!arst_n || (code_ch.valid && code_ch.ready) || (disp_ch.valid && disp_ch.ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles == IDLE_LIMIT) begin
			$display("testbench: FAIL");
			$finish;
		end
	end

endmodule
